>>> rtl/core/cmfr_pkg.sv
// shared types and constants of the CAN multi-frame reassembler
// used by cmfr_front, cmfr_back and can_multiframe_reassembler_core
package cmfr_pkg;

	localparam int SLOT_COUNT_DEF        = 4;
	localparam int MAX_MESSAGE_BYTES_DEF = 255;
	localparam int ROW_BITS              = 5;
	localparam int LANES                 = 8;
	localparam int IN_DATA_W             = 96;
	localparam int OUT_DATA_W            = 104;

	typedef enum logic [1:0] {
		KIND_FIRST   = 2'd0,
		KIND_MIDDLE  = 2'd1,
		KIND_LAST    = 2'd2,
		KIND_RELEASE = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t        kind;
		logic [7:0]   sender;
		logic [15:0]  msg_type;
		logic [3:0]   byte_count;
		logic [63:0]  payload;
	} item_t;

	typedef struct packed {
		logic [7:0]   out_sender;
		logic [15:0]  out_type;
		logic [7:0]   total_length;
		logic [63:0]  word;
		logic [3:0]   word_bytes;
		logic         overflow;
		logic         last_word;
	} result_t;

endpackage

>>> rtl/core/can_multiframe_reassembler_core.sv
// CAN multi-frame reassembler: front queue feeds the slot table and streamer
// a taken item passes from the queue through the match and execute states of the back sequencer
// the back takes no new item until idle again; after a last frame it streams the words, each by a
// memory read then the output register; the two-entry queue absorbs input bursts
// reset (arst_n low) empties the queue, closes all slots and drops any pending word
// depends on cmfr_pkg, cmfr_front, cmfr_back
module can_multiframe_reassembler_core import cmfr_pkg::*; #(
	parameter int SLOT_COUNT        = SLOT_COUNT_DEF,
	parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// sender[7:0], msg_type[23:8], byte_count[27:24], payload[91:28], zero fill
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// kind[1:0]
	input  logic [1:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// out_sender[7:0], out_type[23:8], total_length[31:24], word[95:32],
	// word_bytes[99:96], overflow[100], zero fill
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast
);

	item_t   in_item;
	item_t   q_item;
	logic    q_valid;
	logic    q_ready;
	result_t res;

	// unpack the input item
	always_comb begin
		in_item.kind       = kind_t'(s_axis_tuser);
		in_item.sender     = s_axis_tdata[7:0];
		in_item.msg_type   = s_axis_tdata[23:8];
		in_item.byte_count = s_axis_tdata[27:24];
		in_item.payload    = s_axis_tdata[91:28];
	end

	cmfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item)
	);

	cmfr_back #(
		.SLOT_COUNT        (SLOT_COUNT),
		.MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	// pack the result item
	assign m_axis_tdata = {3'd0, res.overflow, res.word_bytes, res.word,
		res.total_length, res.out_type, res.out_sender};
	assign m_axis_tlast = res.last_word;

	// a word never carries zero or more than eight bytes
	a_word_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (res.word_bytes != 4'd0 && res.word_bytes <= 4'd8))
		else $error("word byte count out of range");

	// only the final word may be short
	a_full_words: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |-> (res.word_bytes == 4'd8))
		else $error("short word before the end of a message");

	// a streamed message is never empty
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (res.total_length != 8'd0))
		else $error("empty message streamed");

endmodule

>>> rtl/core/cmfr_front.sv
// front part: accepts items, clamps the byte count, queues them two deep
// depends on cmfr_pkg
module cmfr_front import cmfr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  q_valid,
	input  logic  q_ready,
	output item_t q_item
);

	item_t       entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push;
	logic        pop;
	item_t       clamped;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = entry_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	// byte counts above eight mean eight
	always_comb begin
		clamped = in_item;
		if (in_item.byte_count > 4'd8) begin
			clamped.byte_count = 4'd8;
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= clamped;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

>>> rtl/core/cmfr_back.sv
// back part: slot table, byte-lane memories and message streaming
// depends on cmfr_pkg
module cmfr_back import cmfr_pkg::*; #(
	parameter int SLOT_COUNT        = SLOT_COUNT_DEF,
	parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_valid,
	output logic    q_ready,
	input  item_t   q_item,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	localparam int SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int DEPTH = SLOT_COUNT * (1 << ROW_BITS);
	localparam int AW    = $clog2(DEPTH);
	localparam logic [7:0] LEN_MAX = 8'(MAX_MESSAGE_BYTES);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MATCH = 5'b00010,
		ST_EXEC  = 5'b00100,
		ST_RD    = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t             state_q;
	logic               valid_q  [SLOT_COUNT];
	logic [7:0]         sender_q [SLOT_COUNT];
	logic [15:0]        type_q   [SLOT_COUNT];
	logic [7:0]         len_q    [SLOT_COUNT];
	logic               ovf_q    [SLOT_COUNT];
	logic [7:0]         mem_q    [LANES][DEPTH];
	logic [7:0]         rd_q     [LANES];

	item_t              item_q;
	logic               hit_q, free_q;
	logic [SW-1:0]      hit_idx_q, free_idx_q;
	logic               hit, free;
	logic [SW-1:0]      hit_idx, free_idx;

	logic [SW-1:0]      cur_s_q;
	logic [7:0]         cur_len_q;
	logic               cur_ovf_q;
	logic [ROW_BITS-1:0] row_q;
	logic               out_valid_q;
	result_t            out_q;

	logic               go;
	logic [SW-1:0]      ex_s;
	logic [7:0]         base_len;
	logic               base_ovf;
	logic [7:0]         avail;
	logic [3:0]         acc;
	logic [7:0]         new_len;
	logic               new_ovf;
	logic               wr_en   [LANES];
	logic [AW-1:0]      wr_addr [LANES];
	logic [7:0]         wr_byte [LANES];
	logic [AW-1:0]      rd_addr;
	logic [SW+ROW_BITS-1:0] rd_cat;

	logic [8:0]         rem;
	logic [3:0]         wb;
	logic               is_last;
	logic               load;
	result_t            nxt;

	assign q_ready   = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// key search, lowest slot wins
	always_comb begin
		hit      = 1'b0;
		free     = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
			if (valid_q[s] && sender_q[s] == item_q.sender && type_q[s] == item_q.msg_type) begin
				hit     = 1'b1;
				hit_idx = SW'(s);
			end
			if (!valid_q[s]) begin
				free     = 1'b1;
				free_idx = SW'(s);
			end
		end
	end

	// append arithmetic with saturation
	always_comb begin
		go       = (item_q.kind == KIND_FIRST) ? (hit_q || free_q) : hit_q;
		ex_s     = (item_q.kind == KIND_FIRST && !hit_q) ? free_idx_q : hit_idx_q;
		base_len = (item_q.kind == KIND_FIRST) ? 8'd0 : len_q[ex_s];
		base_ovf = (item_q.kind == KIND_FIRST) ? 1'b0 : ovf_q[ex_s];
		avail    = LEN_MAX - base_len;
		if ({4'd0, item_q.byte_count} > avail) begin
			acc     = avail[3:0];
			new_ovf = 1'b1;
		end else begin
			acc     = item_q.byte_count;
			new_ovf = base_ovf;
		end
		new_len = base_len + {4'd0, acc};
	end

	// per-lane write: each lane takes at most one byte of a frame
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			logic [2:0] off;
			logic [8:0] sum;
			logic [SW+ROW_BITS-1:0] cat;
			off        = 3'(l) - base_len[2:0];
			sum        = {1'b0, base_len} + {6'd0, off};
			cat        = {ex_s, sum[7:3]};
			wr_en[l]   = (state_q == ST_EXEC) && go && (item_q.kind != KIND_RELEASE)
				&& ({1'b0, off} < acc);
			wr_addr[l] = cat[AW-1:0];
			wr_byte[l] = item_q.payload[{off, 3'b000} +: 8];
		end
	end

	assign rd_cat  = {cur_s_q, row_q};
	assign rd_addr = rd_cat[AW-1:0];

	// byte-lane memories
	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			if (wr_en[l]) begin
				mem_q[l][wr_addr[l]] <= wr_byte[l];
			end
			rd_q[l] <= mem_q[l][rd_addr];
		end
	end

	// next output word
	always_comb begin
		rem     = {1'b0, cur_len_q} - {1'b0, row_q, 3'b000};
		wb      = (rem >= 9'd8) ? 4'd8 : rem[3:0];
		is_last = (rem <= 9'd8);
		load    = (state_q == ST_OUT) && (!out_valid_q || out_ready);
		nxt.out_sender   = item_q.sender;
		nxt.out_type     = item_q.msg_type;
		nxt.total_length = cur_len_q;
		nxt.word_bytes   = wb;
		nxt.overflow     = cur_ovf_q;
		nxt.last_word    = is_last;
		for (int b = 0; b < LANES; b++) begin
			nxt.word[b*8 +: 8] = (4'(b) < wb) ? rd_q[b] : 8'd0;
		end
	end

	// item registers and output payload
	always_ff @(posedge clk) begin
		if (q_valid && q_ready) begin
			item_q <= q_item;
		end
		if (state_q == ST_MATCH) begin
			hit_q      <= hit;
			hit_idx_q  <= hit_idx;
			free_q     <= free;
			free_idx_q <= free_idx;
		end
		if (state_q == ST_EXEC) begin
			cur_s_q   <= ex_s;
			cur_len_q <= new_len;
			cur_ovf_q <= new_ovf;
		end
		if (load) begin
			out_q <= nxt;
		end
	end

	// sequencer and slot table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			row_q       <= '0;
			for (int s = 0; s < SLOT_COUNT; s++) begin
				valid_q[s]  <= 1'b0;
				sender_q[s] <= 8'd0;
				type_q[s]   <= 16'd0;
				len_q[s]    <= 8'd0;
				ovf_q[s]    <= 1'b0;
			end
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) state_q <= ST_MATCH;
				end
				ST_MATCH: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					if (go) begin
						if (item_q.kind == KIND_RELEASE) begin
							valid_q[ex_s] <= 1'b0;
						end else begin
							len_q[ex_s] <= new_len;
							ovf_q[ex_s] <= new_ovf;
						end
						if (item_q.kind == KIND_FIRST) begin
							valid_q[ex_s]  <= 1'b1;
							sender_q[ex_s] <= item_q.sender;
							type_q[ex_s]   <= item_q.msg_type;
						end
						if (item_q.kind == KIND_LAST && new_len != 8'd0) begin
							row_q   <= '0;
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (load) begin
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							row_q   <= row_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> test/tb.sv
// self-checking bench for can_multiframe_reassembler_core
// predicts reassembled message words from accepted frames; depends on cmfr_pkg and the core
`timescale 1ns / 1ps

module tb;
	import cmfr_pkg::*;

	localparam int SLOTS     = SLOT_COUNT_DEF;
	localparam int MAX_BYTES = MAX_MESSAGE_BYTES_DEF;
	localparam int WATCHDOG  = 20000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [1:0]            s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;

	can_multiframe_reassembler_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	// predictor state: slot table copy
	logic        tbl_valid [SLOTS];
	logic [7:0]  tbl_sender [SLOTS];
	logic [15:0] tbl_type [SLOTS];
	logic [7:0]  tbl_len [SLOTS];
	logic        tbl_ovf [SLOTS];
	logic [7:0]  tbl_bytes [SLOTS][256];

	item_t   frame_q[$];
	result_t word_q[$];
	int      errors = 0;
	int      frames_taken = 0;
	int      words_seen = 0;
	int      idle_cycles = 0;
	bit      hold_long = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// gap length: mostly short, some long
	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 3);
	endfunction

	task automatic add_bytes(int s, logic [3:0] cnt, logic [63:0] data);
		int n;
		n = (cnt > 8) ? 8 : cnt;
		for (int i = 0; i < n; i++) begin
			if (tbl_len[s] < MAX_BYTES && tbl_len[s] < 255) begin
				tbl_bytes[s][tbl_len[s]] = data[8*i +: 8];
				tbl_len[s] = tbl_len[s] + 8'd1;
			end else begin
				tbl_ovf[s] = 1'b1;
			end
		end
	endtask

	// update the table for one taken frame and queue the words it releases
	task automatic predict_words(item_t it);
		int s;
		int f;
		result_t r;
		s = -1;
		for (int i = SLOTS - 1; i >= 0; i--)
			if (tbl_valid[i] && tbl_sender[i] == it.sender && tbl_type[i] == it.msg_type) s = i;
		if (it.kind == KIND_FIRST) begin
			if (s < 0) begin
				f = -1;
				for (int i = SLOTS - 1; i >= 0; i--) if (!tbl_valid[i]) f = i;
				if (f < 0) return;
				s = f;
				tbl_valid[s] = 1'b1;
				tbl_sender[s] = it.sender;
				tbl_type[s] = it.msg_type;
			end
			tbl_len[s] = 0;
			tbl_ovf[s] = 1'b0;
			add_bytes(s, it.byte_count, it.payload);
			return;
		end
		if (s < 0) return;
		if (it.kind == KIND_RELEASE) begin
			tbl_valid[s] = 1'b0;
			return;
		end
		add_bytes(s, it.byte_count, it.payload);
		if (it.kind == KIND_MIDDLE) return;
		for (int p = 0; p < tbl_len[s]; p += 8) begin
			r.out_sender = tbl_sender[s];
			r.out_type = tbl_type[s];
			r.total_length = tbl_len[s];
			r.word = '0;
			r.word_bytes = (tbl_len[s] - p > 8) ? 4'd8 : 4'(tbl_len[s] - p);
			for (int b = 0; b < r.word_bytes; b++) r.word[8*b +: 8] = tbl_bytes[s][p + b];
			r.overflow = tbl_ovf[s];
			r.last_word = (p + 8 >= tbl_len[s]);
			word_q.insert(word_q.size(), r);
		end
	endtask

	// append one item to the pending queue
	task automatic add_frame(item_t it);
		frame_q.insert(frame_q.size(), it);
	endtask

	function automatic item_t mk(kind_t k, logic [7:0] snd, logic [15:0] typ,
			logic [3:0] cnt, logic [63:0] data);
		item_t it;
		it.kind = k; it.sender = snd; it.msg_type = typ;
		it.byte_count = cnt; it.payload = data;
		return it;
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom(), $urandom()};
	endfunction

	// driver: offers items from the pending queue with random gaps
	int tx_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			tx_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_words(frame_q.pop_front());
				frames_taken++;
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the offered item
			end else if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (frame_q.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				item_t nx;
				nx = frame_q[0];
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= nx.kind;
				s_axis_tdata <= {4'd0, nx.payload, nx.byte_count, nx.msg_type, nx.sender};
				if (!hold_long) tx_gap <= gap_len();
			end
		end
	end

	// monitor: random stalls plus one long hold-off, checks words in order
	int rx_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_gap <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				result_t got, exp;
				got.out_sender = m_axis_tdata[7:0];
				got.out_type = m_axis_tdata[23:8];
				got.total_length = m_axis_tdata[31:24];
				got.word = m_axis_tdata[95:32];
				got.word_bytes = m_axis_tdata[99:96];
				got.overflow = m_axis_tdata[100];
				got.last_word = m_axis_tlast;
				words_seen++;
				if (word_q.size() == 0) begin
					$error("unexpected word sender=%0h type=%0h", got.out_sender, got.out_type);
					errors++;
				end else begin
					exp = word_q.pop_front();
					if (got.out_sender !== exp.out_sender) begin
						$error("out_sender exp %0h got %0h", exp.out_sender, got.out_sender);
						errors++;
					end
					if (got.out_type !== exp.out_type) begin
						$error("out_type exp %0h got %0h", exp.out_type, got.out_type);
						errors++;
					end
					if (got.total_length !== exp.total_length) begin
						$error("total_length exp %0d got %0d", exp.total_length, got.total_length);
						errors++;
					end
					if (got.word !== exp.word) begin
						$error("word exp %016h got %016h", exp.word, got.word);
						errors++;
					end
					if (got.word_bytes !== exp.word_bytes) begin
						$error("word_bytes exp %0d got %0d", exp.word_bytes, got.word_bytes);
						errors++;
					end
					if (got.overflow !== exp.overflow) begin
						$error("overflow exp %0b got %0b", exp.overflow, got.overflow);
						errors++;
					end
					if (got.last_word !== exp.last_word) begin
						$error("last_word exp %0b got %0b", exp.last_word, got.last_word);
						errors++;
					end
				end
			end
			if (hold_long) begin
				m_axis_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap <= rx_gap - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				rx_gap <= gap_len();
			end
		end
	end

	// watchdog on cycles with no accepted item on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_long)
			idle_cycles <= 0;
		else if (frame_q.size() != 0 || word_q.size() != 0)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("timeout with %0d frames pending, %0d words expected",
				frame_q.size(), word_q.size());
			$display("** can_multiframe_reassembler_core: FAILED **");
			$finish;
		end
	end

	// build a well-formed message on a key: a first frame, n middle frames and a last frame, content random
	task automatic queue_message(logic [7:0] snd, logic [15:0] typ, int n);
		add_frame(mk(KIND_FIRST, snd, typ, 4'($urandom_range(0, 8)), rnd64()));
		for (int i = 0; i < n; i++)
			add_frame(mk(KIND_MIDDLE, snd, typ, 4'($urandom_range(0, 15)), rnd64()));
		add_frame(mk(KIND_LAST, snd, typ, 4'($urandom_range(0, 15)), rnd64()));
		if ($urandom_range(0, 2) != 0)
			add_frame(mk(KIND_RELEASE, snd, typ, 4'($urandom_range(0, 15)), rnd64()));
	endtask

	task automatic wait_drained();
		while (frame_q.size() != 0 || s_axis_tvalid) @(posedge clk);
		while (word_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		logic [7:0]  ks [4];
		logic [15:0] kt [4];
		int k;
		int n;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_valid[i] = 0; tbl_sender[i] = 0; tbl_type[i] = 0;
			tbl_len[i] = 0; tbl_ovf[i] = 0;
		end
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, duplicate first, unmatched, full table, empty, clamped byte count
		add_frame(mk(KIND_MIDDLE, 8'h00, 16'h0000, 4'd8, '1));
		add_frame(mk(KIND_LAST, 8'h00, 16'h0000, 4'd8, '1));
		add_frame(mk(KIND_RELEASE, 8'hff, 16'hffff, 4'd0, '0));
		add_frame(mk(KIND_FIRST, 8'hff, 16'hffff, 4'd8, 64'hffff_ffff_ffff_ffff));
		add_frame(mk(KIND_FIRST, 8'hff, 16'hffff, 4'd3, 64'h0123_4567_89ab_cdef));
		add_frame(mk(KIND_LAST, 8'hff, 16'hffff, 4'd15, 64'h5555_aaaa_5555_aaaa));
		add_frame(mk(KIND_FIRST, 8'h00, 16'h0000, 4'd0, '0));
		add_frame(mk(KIND_LAST, 8'h00, 16'h0000, 4'd0, '0));
		add_frame(mk(KIND_FIRST, 8'h12, 16'h3456, 4'd1, 64'haa));
		add_frame(mk(KIND_FIRST, 8'h12, 16'h3457, 4'd2, 64'hbbcc));
		add_frame(mk(KIND_FIRST, 8'h99, 16'h0001, 4'd8, rnd64()));
		add_frame(mk(KIND_LAST, 8'h99, 16'h0001, 4'd0, '0));
		add_frame(mk(KIND_RELEASE, 8'h00, 16'h0000, 4'd0, '0));
		add_frame(mk(KIND_FIRST, 8'h77, 16'h7777, 4'd8, rnd64()));
		add_frame(mk(KIND_LAST, 8'h77, 16'h7777, 4'd8, rnd64()));
		for (int i = 0; i < SLOTS; i++)
			add_frame(mk(KIND_RELEASE, 8'h12, 16'(16'h3456 + i), 4'd0, '0));
		add_frame(mk(KIND_RELEASE, 8'hff, 16'hffff, 4'd0, '0));
		add_frame(mk(KIND_RELEASE, 8'h99, 16'h0001, 4'd0, '0));
		add_frame(mk(KIND_RELEASE, 8'h77, 16'h7777, 4'd0, '0));
		wait_drained();

		// long message past the byte limit, with the receiver held off meanwhile
		add_frame(mk(KIND_FIRST, 8'h5a, 16'ha55a, 4'd8, rnd64()));
		for (int i = 0; i < 33; i++)
			add_frame(mk(KIND_MIDDLE, 8'h5a, 16'ha55a, 4'd8, rnd64()));
		add_frame(mk(KIND_LAST, 8'h5a, 16'ha55a, 4'd8, rnd64()));
		add_frame(mk(KIND_LAST, 8'h5a, 16'ha55a, 4'd2, rnd64()));
		add_frame(mk(KIND_RELEASE, 8'h5a, 16'ha55a, 4'd0, '0));
		hold_long = 1;
		repeat (300) @(posedge clk);
		hold_long = 0;
		wait_drained();

		// random part: mostly well-formed messages over a small key set
		for (int i = 0; i < 4; i++) begin
			ks[i] = 8'($urandom());
			kt[i] = 16'($urandom());
		end
		while (frame_q.size() < 410) begin
			k = $urandom_range(0, 3);
			if ($urandom_range(0, 7) == 0) begin
				add_frame(mk(kind_t'($urandom_range(0, 3)),
					($urandom_range(0, 1)) ? ks[k] : 8'($urandom()),
					($urandom_range(0, 1)) ? kt[k] : 16'($urandom()),
					4'($urandom()), rnd64()));
			end else begin
				n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 34) : $urandom_range(0, 4);
				queue_message(ks[k], kt[k], n);
			end
		end
		wait_drained();
		repeat (50) @(posedge clk);

		$display("covered %0d frames and %0d message words, incl. overflow and full table",
			frames_taken, words_seen);
		if (errors == 0 && word_q.size() == 0) begin
			$display("** can_multiframe_reassembler_core: PASSED **");
		end else begin
			$display("** can_multiframe_reassembler_core: FAILED **");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/cmfr_pkg.sv
rtl/core/cmfr_front.sv
rtl/core/cmfr_back.sv
rtl/core/can_multiframe_reassembler_core.sv
test/tb.sv
